// File: rtl/core/rce_pkg.sv
`timescale 1ns / 1ps
package rce_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam int GROUP_BYTES    = 8;
  localparam int GIDX_W         = $clog2(GROUP_BYTES);
  localparam int GCNT_W         = GIDX_W + 1;
  localparam int DEC_W          = 7;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // one encoded byte on its way to the group packer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } byte_beat_t;

  // end of line seen by the tokenizer
  typedef struct packed {
    logic start;
    logic ovf;
  } line_done_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // v / 10 by reciprocal, exact for the 7-bit range
  function automatic logic [3:0] dec_tens(input logic [DEC_W-1:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] dec_ones(input logic [DEC_W-1:0] v);
    logic [3:0]       t;
    logic [DEC_W-1:0] r;
    t = dec_tens(v);
    r = v - DEC_W'(t) * DEC_W'(10);
    return r[3:0];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CH_ZERO + 8'(d);
  endfunction

endpackage

// File: rtl/core/rce_ram.sv
`timescale 1ns / 1ps
module rce_ram #(
  parameter int W  = 8,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/rce_tokenizer.sv
`timescale 1ns / 1ps
module rce_tokenizer #(
  parameter int LINE_BYTES = rce_pkg::LINE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [7:0]                        data_byte,
  input  logic                              byte_valid,
  input  logic                              end_of_line,
  output logic                              line_we,
  output logic [$clog2(LINE_BYTES)-1:0]     line_waddr,
  output logic [7:0]                        line_wdata,
  output logic                              tok_we,
  output logic [(($clog2(LINE_BYTES) > 1) ? $clog2(LINE_BYTES) - 1 : 1)-1:0] tok_waddr,
  output logic [2*$clog2(LINE_BYTES):0]     tok_wdata,
  output rce_pkg::line_done_t               done,
  output logic [(($clog2(LINE_BYTES) > 1) ? $clog2(LINE_BYTES) - 1 : 1):0] done_tokens
);

  localparam int LAW = $clog2(LINE_BYTES);
  localparam int CW  = LAW + 1;
  localparam int TAW = (LAW > 1) ? LAW - 1 : 1;
  localparam int TW  = TAW + 1;

  logic [CW-1:0]  stored, stored_next;
  logic [TW-1:0]  total, total_next;
  logic           in_word, in_word_next;
  logic           ovf_seen, ovf_next;
  logic [LAW-1:0] cur_start, cur_start_next;
  logic [CW-1:0]  cur_len, cur_len_next;
  logic           keep;

  always_comb begin
    keep           = accept && byte_valid && (stored < CW'(LINE_BYTES));
    stored_next    = stored;
    total_next     = total;
    in_word_next   = in_word;
    ovf_next       = ovf_seen;
    cur_start_next = cur_start;
    cur_len_next   = cur_len;
    tok_we         = 1'b0;
    tok_waddr      = total[TAW-1:0];
    tok_wdata      = {cur_start, cur_len};
    if (accept && byte_valid && !keep) begin
      ovf_next = 1'b1;
    end
    if (keep) begin
      stored_next = stored + CW'(1);
      if (rce_pkg::is_blank(data_byte)) begin
        in_word_next = 1'b0;
      end else if (!in_word) begin
        in_word_next = 1'b1;
        if (total < TW'(1 << TAW)) begin
          tok_we         = 1'b1;
          tok_waddr      = total[TAW-1:0];
          tok_wdata      = {stored[LAW-1:0], CW'(1)};
          total_next     = total + TW'(1);
          cur_start_next = stored[LAW-1:0];
          cur_len_next   = CW'(1);
        end
      end else if ((total != '0) && (total <= TW'(1 << TAW))) begin
        // open token grows, rewrite its entry
        cur_len_next = cur_len + CW'(1);
        tok_we       = 1'b1;
        tok_waddr    = TAW'(total - TW'(1));
        tok_wdata    = {cur_start, cur_len_next};
      end
    end
  end

  assign line_we     = keep;
  assign line_waddr  = stored[LAW-1:0];
  assign line_wdata  = data_byte;
  assign done.start  = accept && end_of_line;
  assign done.ovf    = ovf_next;
  assign done_tokens = total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored   <= '0;
      total    <= '0;
      in_word  <= 1'b0;
      ovf_seen <= 1'b0;
    end else if (accept && end_of_line) begin
      stored   <= '0;
      total    <= '0;
      in_word  <= 1'b0;
      ovf_seen <= 1'b0;
    end else begin
      stored   <= stored_next;
      total    <= total_next;
      in_word  <= in_word_next;
      ovf_seen <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_start <= cur_start_next;
    cur_len   <= cur_len_next;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= CW'(LINE_BYTES))
    else $error("line fill count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf_seen |-> (stored == CW'(LINE_BYTES)))
    else $error("overflow flagged before line store is full");

endmodule

// File: rtl/core/rce_emitter.sv
`timescale 1ns / 1ps
module rce_emitter #(
  parameter int LINE_BYTES = rce_pkg::LINE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rce_pkg::line_done_t               done,
  input  logic [(($clog2(LINE_BYTES) > 1) ? $clog2(LINE_BYTES) - 1 : 1):0] done_tokens,
  output logic                              busy,
  output logic                              tok_re,
  output logic [(($clog2(LINE_BYTES) > 1) ? $clog2(LINE_BYTES) - 1 : 1)-1:0] tok_raddr,
  input  logic [2*$clog2(LINE_BYTES):0]     tok_rdata,
  output logic                              line_re,
  output logic [$clog2(LINE_BYTES)-1:0]     line_raddr,
  input  logic [7:0]                        line_rdata,
  output rce_pkg::byte_beat_t               beat,
  input  logic                              beat_ready
);

  localparam int LAW = $clog2(LINE_BYTES);
  localparam int CW  = LAW + 1;
  localparam int TAW = (LAW > 1) ? LAW - 1 : 1;
  localparam int TW  = TAW + 1;

  typedef enum logic [3:0] {
    E_IDLE, E_STAR, E_CNT_T, E_CNT_O, E_CR, E_LF, E_FETCH, E_DOLLAR,
    E_LEN_T, E_LEN_O, E_LCR, E_LLF, E_DATA, E_DCR, E_DLF
  } state_t;

  state_t         state, state_next;
  logic [TW-1:0]  tok_total;
  logic [TW-1:0]  tok_idx;
  logic [CW-1:0]  data_i;
  logic           ovf;
  logic           s2_valid, s2_mem, s2_last, s2_ovf;
  logic [7:0]     s2_lit;

  logic [LAW-1:0]             tk_start;
  logic [CW-1:0]              tk_len;
  logic [rce_pkg::DEC_W-1:0]  tot7, len7;
  logic                       s2_free, emit, is_mem, last, step;
  logic [7:0]                 lit;

  assign tk_start = tok_rdata[LAW+CW-1:CW];
  assign tk_len   = tok_rdata[CW-1:0];
  assign tot7     = rce_pkg::DEC_W'(tok_total);
  assign len7     = rce_pkg::DEC_W'(tk_len);
  assign s2_free  = !s2_valid || beat_ready;

  always_comb begin
    emit       = 1'b1;
    is_mem     = 1'b0;
    last       = 1'b0;
    lit        = rce_pkg::CH_CR;
    state_next = state;
    unique case (state)
      E_IDLE: begin
        emit = 1'b0;
      end
      E_STAR: begin
        lit        = rce_pkg::CH_STAR;
        state_next = (tot7 >= rce_pkg::DEC_W'(10)) ? E_CNT_T : E_CNT_O;
      end
      E_CNT_T: begin
        lit        = rce_pkg::digit_char(rce_pkg::dec_tens(tot7));
        state_next = E_CNT_O;
      end
      E_CNT_O: begin
        lit        = rce_pkg::digit_char(rce_pkg::dec_ones(tot7));
        state_next = E_CR;
      end
      E_CR: begin
        state_next = E_LF;
      end
      E_LF: begin
        lit = rce_pkg::CH_LF;
        if (tok_total == '0) begin
          last       = 1'b1;
          state_next = E_IDLE;
        end else begin
          state_next = E_FETCH;
        end
      end
      E_FETCH: begin
        emit       = 1'b0;
        state_next = E_DOLLAR;
      end
      E_DOLLAR: begin
        lit        = rce_pkg::CH_DOLLAR;
        state_next = (len7 >= rce_pkg::DEC_W'(10)) ? E_LEN_T : E_LEN_O;
      end
      E_LEN_T: begin
        lit        = rce_pkg::digit_char(rce_pkg::dec_tens(len7));
        state_next = E_LEN_O;
      end
      E_LEN_O: begin
        lit        = rce_pkg::digit_char(rce_pkg::dec_ones(len7));
        state_next = E_LCR;
      end
      E_LCR: begin
        state_next = E_LLF;
      end
      E_LLF: begin
        lit        = rce_pkg::CH_LF;
        state_next = E_DATA;
      end
      E_DATA: begin
        is_mem     = 1'b1;
        state_next = ((data_i + CW'(1)) == tk_len) ? E_DCR : E_DATA;
      end
      E_DCR: begin
        state_next = E_DLF;
      end
      E_DLF: begin
        lit = rce_pkg::CH_LF;
        if ((tok_idx + TW'(1)) == tok_total) begin
          last       = 1'b1;
          state_next = E_IDLE;
        end else begin
          state_next = E_FETCH;
        end
      end
      default: begin
        emit       = 1'b0;
        state_next = E_IDLE;
      end
    endcase
    step = emit ? s2_free : 1'b1;
  end

  assign busy       = (state != E_IDLE);
  assign tok_re     = (state == E_FETCH);
  assign tok_raddr  = tok_idx[TAW-1:0];
  // the line read is issued as the byte moves into the output stage
  assign line_re    = (state == E_DATA) && s2_free;
  assign line_raddr = tk_start + data_i[LAW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      s2_valid <= 1'b0;
    end else begin
      if (state == E_IDLE) begin
        if (done.start) begin
          state     <= E_STAR;
          tok_total <= done_tokens;
          ovf       <= done.ovf;
          tok_idx   <= '0;
        end
      end else if (step) begin
        state <= state_next;
        if (state == E_DOLLAR) begin
          data_i <= '0;
        end
        if (state == E_DATA) begin
          data_i <= data_i + CW'(1);
        end
        if (state == E_DLF) begin
          tok_idx <= tok_idx + TW'(1);
        end
      end
      if (emit && s2_free) begin
        s2_valid <= 1'b1;
        s2_mem   <= is_mem;
        s2_lit   <= lit;
        s2_last  <= last;
        s2_ovf   <= ovf;
      end else if (beat_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  assign beat.valid = s2_valid;
  assign beat.data  = s2_mem ? line_rdata : s2_lit;
  assign beat.last  = s2_last;
  assign beat.ovf   = s2_ovf;

endmodule

// File: rtl/core/rce_packer.sv
`timescale 1ns / 1ps
module rce_packer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rce_pkg::byte_beat_t                   beat,
  output logic                                  beat_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rce_pkg::GROUP_BYTES-1:0][7:0]  grp_bytes,
  output logic [rce_pkg::GCNT_W-1:0]            valid_bytes,
  output logic                                  last_group,
  output logic                                  overflow
);

  localparam int GB = rce_pkg::GROUP_BYTES;
  localparam int GC = rce_pkg::GCNT_W;

  logic [GB-1:0][7:0] acc;
  logic [GC-1:0]      acc_cnt;
  logic               acc_done;
  logic               acc_ovf;
  logic               full, out_free, flush, take;

  assign full       = (acc_cnt == GC'(GB)) || acc_done;
  assign out_free   = !out_valid || out_ready;
  assign flush      = full && out_free;
  assign beat_ready = !full || flush;
  assign take       = beat.valid && beat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc_cnt   <= '0;
      acc_done  <= 1'b0;
    end else begin
      if (flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        acc_cnt  <= flush ? GC'(1) : acc_cnt + GC'(1);
        acc_done <= beat.last;
      end else if (flush) begin
        acc_cnt  <= '0;
        acc_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc[flush ? '0 : acc_cnt[rce_pkg::GIDX_W-1:0]] <= beat.data;
      acc_ovf <= beat.ovf;
    end
    if (flush) begin
      // unused byte lanes go out as zero
      for (int i = 0; i < GB; i++) begin
        grp_bytes[i] <= (GC'(i) < acc_cnt) ? acc[i] : 8'h00;
      end
      valid_bytes <= acc_cnt;
      last_group  <= acc_done;
      overflow    <= acc_ovf;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((valid_bytes != '0) && (valid_bytes <= GC'(GB))))
    else $error("group byte count out of range");

  a_short_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_group) |-> (valid_bytes == GC'(GB)))
    else $error("short group that is not the last one");

endmodule

// File: rtl/core/resp_command_encoder.sv
`timescale 1ns / 1ps
// line bytes are taken one per cycle while no message is being emitted; each kept
// byte is written to the line store; after the end-of-line transfer the encoder
// emits one message byte per cycle unless the output holds it off, with a token
// table read before each token; input is held off meanwhile
// synchronous reset clears counters, sequencer and valid flags; the stores are not cleared
module resp_command_encoder #(
  parameter int LINE_BYTES = rce_pkg::LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_0,
  output logic [7:0] out_byte_1,
  output logic [7:0] out_byte_2,
  output logic [7:0] out_byte_3,
  output logic [7:0] out_byte_4,
  output logic [7:0] out_byte_5,
  output logic [7:0] out_byte_6,
  output logic [7:0] out_byte_7,
  output logic [3:0] valid_bytes,
  output logic       last_group,
  output logic       overflow
);

  localparam int LAW = $clog2(LINE_BYTES);
  localparam int CW  = LAW + 1;
  localparam int TAW = (LAW > 1) ? LAW - 1 : 1;
  localparam int TW  = TAW + 1;

  logic                 accept, busy;
  logic                 line_we, line_re;
  logic [LAW-1:0]       line_waddr, line_raddr;
  logic [7:0]           line_wdata, line_rdata;
  logic                 tok_we, tok_re;
  logic [TAW-1:0]       tok_waddr, tok_raddr;
  logic [LAW+CW-1:0]    tok_wdata, tok_rdata;
  rce_pkg::line_done_t  done;
  logic [TW-1:0]        done_tokens;
  rce_pkg::byte_beat_t  beat;
  logic                 beat_ready;
  logic [rce_pkg::GROUP_BYTES-1:0][7:0] grp_bytes;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  rce_tokenizer #(.LINE_BYTES(LINE_BYTES)) u_tok (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .end_of_line (end_of_line),
    .line_we     (line_we),
    .line_waddr  (line_waddr),
    .line_wdata  (line_wdata),
    .tok_we      (tok_we),
    .tok_waddr   (tok_waddr),
    .tok_wdata   (tok_wdata),
    .done        (done),
    .done_tokens (done_tokens)
  );

  rce_ram #(.W(8), .AW(LAW)) u_line_store (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  rce_ram #(.W(LAW + CW), .AW(TAW)) u_token_table (
    .clk   (clk),
    .we    (tok_we),
    .waddr (tok_waddr),
    .wdata (tok_wdata),
    .re    (tok_re),
    .raddr (tok_raddr),
    .rdata (tok_rdata)
  );

  rce_emitter #(.LINE_BYTES(LINE_BYTES)) u_emit (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .done_tokens (done_tokens),
    .busy        (busy),
    .tok_re      (tok_re),
    .tok_raddr   (tok_raddr),
    .tok_rdata   (tok_rdata),
    .line_re     (line_re),
    .line_raddr  (line_raddr),
    .line_rdata  (line_rdata),
    .beat        (beat),
    .beat_ready  (beat_ready)
  );

  rce_packer u_pack (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .beat_ready  (beat_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .grp_bytes   (grp_bytes),
    .valid_bytes (valid_bytes),
    .last_group  (last_group),
    .overflow    (overflow)
  );

  assign out_byte_0 = grp_bytes[0];
  assign out_byte_1 = grp_bytes[1];
  assign out_byte_2 = grp_bytes[2];
  assign out_byte_3 = grp_bytes[3];
  assign out_byte_4 = grp_bytes[4];
  assign out_byte_5 = grp_bytes[5];
  assign out_byte_6 = grp_bytes[6];
  assign out_byte_7 = grp_bytes[7];

endmodule

// File: test/tb_resp_command_encoder.sv
`timescale 1ns / 1ps
module tb_resp_command_encoder;

  localparam int LINE_CAP    = rce_pkg::LINE_BYTES_DEF;
  localparam int TOKEN_SLOTS = 32;
  localparam int RAND_ITEMS  = 320;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      count;
    logic            last;
    logic            ovf;
  } group_t;

  typedef struct packed {
    logic [7:0] d;
    logic       bv;
    logic       eol;
    logic       typed;
    group_t     grp;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] d;
    logic       bv;
    logic       eol;
  } line_item_t;

  localparam group_t NO_MSG = '0;
  localparam group_t EMPTY_MSG = '{
    bytes: {8'h00, 8'h00, 8'h00, 8'h00,
            rce_pkg::CH_LF, rce_pkg::CH_CR, rce_pkg::CH_ZERO, rce_pkg::CH_STAR},
    count: 4'd4, last: 1'b1, ovf: 1'b0};

  // d, byte_valid, end_of_line, typed, expected group
  localparam dir_row_t DIR_ROWS [25] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_MSG},  // empty line straight after reset
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_MSG},     // ignored
    '{8'h5A, 1'b0, 1'b1, 1'b1, EMPTY_MSG},  // data present but not valid
    '{8'h20, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h09, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h53, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h45, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h54, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h0D, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h0B, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h0C, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h80, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h0A, 1'b1, 1'b1, 1'b0, NO_MSG},
    '{8'h08, 1'b1, 1'b1, 1'b0, NO_MSG},     // single token carried by the eol transfer
    '{8'h20, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h0D, 1'b1, 1'b1, 1'b1, EMPTY_MSG},  // whitespace only
    '{8'h0E, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h1F, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h21, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h7F, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h09, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h41, 1'b1, 1'b0, 1'b0, NO_MSG},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_MSG}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       byte_valid = 1'b0;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_0, out_byte_1, out_byte_2, out_byte_3;
  logic [7:0] out_byte_4, out_byte_5, out_byte_6, out_byte_7;
  logic [3:0] valid_bytes;
  logic       last_group;
  logic       overflow;

  resp_command_encoder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_valid(byte_valid), .end_of_line(end_of_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte_0(out_byte_0), .out_byte_1(out_byte_1),
    .out_byte_2(out_byte_2), .out_byte_3(out_byte_3),
    .out_byte_4(out_byte_4), .out_byte_5(out_byte_5),
    .out_byte_6(out_byte_6), .out_byte_7(out_byte_7),
    .valid_bytes(valid_bytes), .last_group(last_group), .overflow(overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // line tokenizer mirror
  logic [7:0] line_bytes [LINE_CAP];
  logic [5:0] tok_start [TOKEN_SLOTS];
  logic [6:0] tok_len [TOKEN_SLOTS];
  logic [6:0] kept_bytes = '0;
  logic [5:0] tok_count = '0;
  logic       in_tok = 1'b0;
  logic       dropped = 1'b0;

  logic [7:0] enc_msg [$];
  group_t     expected_groups [$];
  line_item_t cur_line [$];

  int send_idle = 37;
  int recv_idle = 45;
  int fail_count = 0;
  int stall_cycles = 0;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void put_msg_byte(input logic [7:0] c);
    enc_msg.insert(enc_msg.size(), c);
  endfunction

  function automatic void queue_group(input group_t g);
    expected_groups.insert(expected_groups.size(), g);
  endfunction

  function automatic void add_decimal(input int unsigned v);
    if (v >= 100) put_msg_byte(rce_pkg::CH_ZERO + 8'((v / 100) % 10));
    if (v >= 10) put_msg_byte(rce_pkg::CH_ZERO + 8'((v / 10) % 10));
    put_msg_byte(rce_pkg::CH_ZERO + 8'(v % 10));
  endfunction

  function automatic void add_crlf();
    put_msg_byte(rce_pkg::CH_CR);
    put_msg_byte(rce_pkg::CH_LF);
  endfunction

  // updates the tokenizer mirror; on end of line builds the groups
  function automatic void tokenize_and_encode(input logic [7:0] d, input logic bv,
                                              input logic eol, input bit keep);
    group_t      g;
    int unsigned pos;
    int unsigned cnt;
    logic [5:0]  idx;
    if (bv) begin
      if (kept_bytes >= LINE_CAP) begin
        dropped = 1'b1;
      end else begin
        line_bytes[kept_bytes[5:0]] = d;
        if (blank_char(d)) begin
          in_tok = 1'b0;
        end else if (!in_tok) begin
          if (tok_count < TOKEN_SLOTS) begin
            tok_start[tok_count[4:0]] = kept_bytes[5:0];
            tok_len[tok_count[4:0]] = 7'd1;
            tok_count = tok_count + 6'd1;
          end
          in_tok = 1'b1;
        end else if (tok_count > 0 && tok_count <= TOKEN_SLOTS) begin
          tok_len[tok_count - 6'd1] = tok_len[tok_count - 6'd1] + 7'd1;
        end
        kept_bytes = kept_bytes + 7'd1;
      end
    end
    if (!eol) return;
    enc_msg.delete();
    put_msg_byte(rce_pkg::CH_STAR);
    add_decimal(tok_count);
    add_crlf();
    for (int t = 0; t < tok_count && t < TOKEN_SLOTS; t++) begin
      put_msg_byte(rce_pkg::CH_DOLLAR);
      add_decimal(tok_len[t]);
      add_crlf();
      for (int i = 0; i < tok_len[t]; i++) begin
        idx = tok_start[t] + 6'(i);
        put_msg_byte(line_bytes[idx]);
      end
      add_crlf();
    end
    pos = 0;
    while (pos < enc_msg.size()) begin
      g = '0;
      cnt = enc_msg.size() - pos;
      if (cnt > 8) cnt = 8;
      for (int i = 0; i < cnt; i++) g.bytes[i] = enc_msg[pos + i];
      g.count = 4'(cnt);
      pos += cnt;
      g.last = (pos == enc_msg.size());
      g.ovf = dropped;
      if (keep) queue_group(g);
    end
    kept_bytes = '0;
    tok_count = '0;
    in_tok = 1'b0;
    dropped = 1'b0;
  endfunction

  // valid stays high from one transfer into the next unless the sender idles
  task automatic send_item(input logic [7:0] d, input logic bv, input logic eol,
                           input bit keep);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    byte_valid <= bv;
    end_of_line <= eol;
    do @(posedge clk); while (!in_ready);
    tokenize_and_encode(d, bv, eol, keep);
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 5))
      0: return 8'h09;
      1: return 8'h0A;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] random_token_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 75) return 8'($urandom_range(8'h41, 8'h7A));
    do c = 8'($urandom_range(0, 255)); while (blank_char(c));
    return c;
  endfunction

  function automatic void add_byte(input logic [7:0] d);
    line_item_t item;
    item = '{d: d, bv: 1'b1, eol: 1'b0};
    cur_line.insert(cur_line.size(), item);
  endfunction

  always @(posedge clk) begin : group_check
    group_t seen;
    group_t want;
    if (!rst && out_valid && out_ready) begin
      seen = '{bytes: {out_byte_7, out_byte_6, out_byte_5, out_byte_4,
                       out_byte_3, out_byte_2, out_byte_1, out_byte_0},
               count: valid_bytes, last: last_group, ovf: overflow};
      if (expected_groups.size() == 0) begin
        $error("unexpected group: valid_bytes %0d last_group %0b", seen.count, seen.last);
        fail_count++;
      end else begin
        want = expected_groups.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (seen.bytes[i] !== want.bytes[i]) begin
            $error("out_byte_%0d: expected %02h, actual %02h", i, want.bytes[i], seen.bytes[i]);
            fail_count++;
          end
        end
        if (seen.count !== want.count) begin
          $error("valid_bytes: expected %0d, actual %0d", want.count, seen.count);
          fail_count++;
        end
        if (seen.last !== want.last) begin
          $error("last_group: expected %0b, actual %0b", want.last, seen.last);
          fail_count++;
        end
        if (seen.ovf !== want.ovf) begin
          $error("overflow: expected %0b, actual %0b", want.ovf, seen.ovf);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[resp_command_encoder] ERROR");
      $finish;
    end
  end

  initial begin
    int rnd_items;
    int kind;
    int ntok;
    int len;
    line_item_t tail_item;
    rnd_items = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[r]) begin
      send_item(DIR_ROWS[r].d, DIR_ROWS[r].bv, DIR_ROWS[r].eol, !DIR_ROWS[r].typed);
      if (DIR_ROWS[r].typed) queue_group(DIR_ROWS[r].grp);
    end

    for (int line_no = 0; rnd_items < RAND_ITEMS; line_no++) begin
      if (rnd_items < RAND_ITEMS / 3) begin
        send_idle = 37;
        recv_idle = 45;
      end else if (rnd_items < 2 * RAND_ITEMS / 3) begin
        send_idle = 45;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      cur_line.delete();
      kind = (line_no == 0) ? -1 : $urandom_range(0, 99);
      if (kind < 0) begin
        // full token table, then a token cut off at the line limit
        for (int i = 0; i < LINE_CAP + 3; i++)
          add_byte((i % 2 == 1 || i >= LINE_CAP) ? random_token_char() : random_blank());
      end else if (kind < 60) begin
        // well-formed command with random words
        ntok = $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0) add_byte(random_blank());
        for (int t = 0; t < ntok; t++) begin
          if (t > 0) repeat ($urandom_range(1, 3)) add_byte(random_blank());
          repeat ($urandom_range(1, 8)) add_byte(random_token_char());
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_byte(random_blank());
      end else if (kind < 75) begin
        len = $urandom_range(0, 24);
        repeat (len) add_byte(($urandom_range(0, 9) < 3) ? random_blank()
                                                          : 8'($urandom_range(0, 255)));
      end else if (kind < 81) begin
        len = $urandom_range(56, 72);
        repeat (len) add_byte(($urandom_range(0, 4) == 0) ? random_blank()
                                                          : 8'($urandom_range(0, 255)));
      end else if (kind < 87) begin
        len = $urandom_range(60, 68);
        for (int i = 0; i < len; i++)
          add_byte((i % 2 == 0) ? random_token_char() : random_blank());
      end else begin
        repeat ($urandom_range(0, 4)) add_byte(random_blank());
      end
      if (cur_line.size() > 0 && $urandom_range(0, 1) == 1) begin
        cur_line[cur_line.size() - 1].eol = 1'b1;
      end else begin
        tail_item = '{d: 8'($urandom_range(0, 255)), bv: 1'b0, eol: 1'b1};
        cur_line.insert(cur_line.size(), tail_item);
      end
      foreach (cur_line[j]) begin
        if ($urandom_range(0, 99) < 8)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
        send_item(cur_line[j].d, cur_line[j].bv, cur_line[j].eol, 1'b1);
        rnd_items++;
      end
    end
    in_valid <= 1'b0;

    while (expected_groups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[resp_command_encoder] OK");
    end else begin
      $display("[resp_command_encoder] ERROR");
    end
    $finish;
  end

endmodule
